/* sv/csem_pkg.sv */
package csem_pkg;

    // Two's complement semaphore count, wide enough for 0..65535 and the waiters below zero
    localparam int COUNT_W = 17;
    localparam int CFG_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65535;

    // Request operation codes
    localparam logic [1:0] FUNC_WAIT   = 2'd0;
    localparam logic [1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [1:0] FUNC_CLOSE  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BLOCKED = 2'd1;
    localparam logic [1:0] STATUS_CLOSED  = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } state_t;

endpackage

/* sv/csem_ram.sv */
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Hold the last read word until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/counting_semaphore_wait_queue_unit.sv */
// Counting semaphore with a FIFO wait queue of QUEUE_DEPTH thread ids held in a
// synchronous RAM. Requests arrive on the s_ stream (tuser = operation, tdata = thread id)
// and results leave on the m_ stream (tuser = status and released flag, tdata = released
// thread, tlast on the final result of a request). One request is handled at a time: a wait,
// a signal that releases nothing, a close of an empty queue or an unused operation is
// accepted and then executed; a signal that releases a thread adds the queue RAM read; a
// close of a non-empty queue drains every queued thread through the single RAM read port at
// one word per cycle while m_tready stays high. Writing cfg_data loads the count, reopens
// the semaphore and empties the queue without releasing anyone; it is taken in any cycle
// but is meant for an idle block.
module counting_semaphore_wait_queue_unit #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // thread_id
    input  logic [((THREAD_ID_BITS+7)/8)*8-1:0]       s_tdata,
    // func
    input  logic [1:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // released_thread
    output logic [((THREAD_ID_BITS+7)/8)*8-1:0]       m_tdata,
    // status [1:0], released_valid [2]
    output logic [2:0]                                m_tuser,
    output logic                                      m_tlast,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [csem_pkg::CFG_W-1:0]                cfg_data
);
    import csem_pkg::*;

    localparam int DATA_W = ((THREAD_ID_BITS + 7) / 8) * 8;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int USED_W = $clog2(QUEUE_DEPTH + 1);

    state_t                    state_reg, state_next;
    logic [1:0]                req_func_reg, req_func_next;
    logic [THREAD_ID_BITS-1:0] req_thread_reg, req_thread_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      open_reg, open_next;
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [USED_W-1:0]         used_reg, used_next;

    logic                      m_valid_reg, m_valid_next;
    logic [1:0]                out_status_reg, out_status_next;
    logic                      out_rvalid_reg, out_rvalid_next;
    logic [THREAD_ID_BITS-1:0] out_thread_reg, out_thread_next;
    logic                      out_last_reg, out_last_next;

    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [PTR_W-1:0]          ram_rd_addr;
    logic [THREAD_ID_BITS-1:0] ram_rd_data;

    logic                      out_free;
    logic                      count_le_zero;
    logic [PTR_W-1:0]          head_inc;
    logic [PTR_W-1:0]          tail_inc;

    csem_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (req_thread_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free      = !m_valid_reg || m_tready;
    assign count_le_zero = count_reg[COUNT_W-1] || (count_reg == '0);
    assign head_inc      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc      = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            open_reg    <= 1'b1;
            head_reg    <= '0;
            tail_reg    <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            open_reg    <= open_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_func_reg   <= req_func_next;
        req_thread_reg <= req_thread_next;
        out_status_reg <= out_status_next;
        out_rvalid_reg <= out_rvalid_next;
        out_thread_reg <= out_thread_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_func_next   = req_func_reg;
        req_thread_next = req_thread_reg;
        count_next      = count_reg;
        open_next       = open_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_rvalid_next = out_rvalid_reg;
        out_thread_next = out_thread_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_func_next   = s_tuser;
                    req_thread_next = s_tdata[THREAD_ID_BITS-1:0];
                    state_next      = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // Default result: one word, nothing released; hold a waiting word
                if (out_free)
                begin
                    out_status_next = STATUS_OK;
                    out_rvalid_next = 1'b0;
                    out_thread_next = '0;
                    out_last_next   = 1'b1;
                end
                priority if (req_func_reg == FUNC_CLOSE)
                begin
                    if (used_reg == '0)
                    begin
                        if (out_free)
                        begin
                            open_next    = 1'b0;
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    else
                    begin
                        open_next  = 1'b0;
                        ram_rd_en  = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (req_func_reg != FUNC_WAIT && req_func_reg != FUNC_SIGNAL)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (!open_reg)
                begin
                    if (out_free)
                    begin
                        out_status_next = STATUS_CLOSED;
                        m_valid_next    = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (req_func_reg == FUNC_WAIT)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                        if (!count_le_zero)
                        begin
                            count_next = count_reg - COUNT_W'(1);
                        end
                        else if (used_reg == USED_W'(QUEUE_DEPTH))
                        begin
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // Park the caller at the tail
                            ram_wr_en       = 1'b1;
                            tail_next       = tail_inc;
                            used_next       = used_reg + USED_W'(1);
                            count_next      = count_reg - COUNT_W'(1);
                            out_status_next = STATUS_BLOCKED;
                        end
                    end
                end
                else
                begin
                    if (count_reg[COUNT_W-1] && used_reg != '0)
                    begin
                        // Fetch the oldest waiter; the result word is built in ST_READ
                        count_next = count_reg + COUNT_W'(1);
                        ram_rd_en  = 1'b1;
                        state_next = ST_READ;
                    end
                    else if (out_free)
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    out_status_next = STATUS_OK;
                    out_rvalid_next = 1'b1;
                    out_thread_next = ram_rd_data;
                    out_last_next   = (req_func_reg != FUNC_CLOSE) || (used_reg == USED_W'(1));
                    m_valid_next    = 1'b1;
                    head_next       = head_inc;
                    used_next       = used_reg - USED_W'(1);
                    if (req_func_reg == FUNC_CLOSE && used_reg > USED_W'(1))
                    begin
                        // Keep draining: fetch the next entry
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_inc;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register write: reload count, reopen, drop the queue
        if (cfg_valid)
        begin
            count_next = COUNT_W'(cfg_data);
            open_next  = 1'b1;
            head_next  = '0;
            tail_next  = '0;
            used_next  = '0;
            state_next = ST_IDLE;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = DATA_W'(out_thread_reg);
    assign m_tuser   = {out_rvalid_reg, out_status_reg};
    assign m_tlast   = out_last_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(QUEUE_DEPTH))
        else $error("wait queue occupancy above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0 || used_reg == USED_W'(QUEUE_DEPTH)) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with occupancy");

    a_neg_count_waiters: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg && state_reg == ST_IDLE && count_reg[COUNT_W-1])
            |-> (count_reg + COUNT_W'(used_reg)) == '0)
        else $error("negative count does not match number of waiters");

    a_pos_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg && state_reg == ST_IDLE && !count_reg[COUNT_W-1]) |-> used_reg == '0)
        else $error("waiters queued while count is not negative");
`endif

endmodule

/* tb/tb_counting_semaphore_wait_queue_unit.sv */
`timescale 1ns / 100ps

module tb_counting_semaphore_wait_queue_unit;

    import csem_pkg::*;

    localparam int WAIT_DEPTH = 16;
    localparam int TID_W      = 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 72;

    typedef struct packed {
        logic [1:0]       status;
        logic             rel_valid;
        logic [TID_W-1:0] rel_thread;
        logic             last;
    } sem_word_t;

    class sem_mirror;
        logic signed [COUNT_W-1:0] count;
        bit                        is_open;
        logic [TID_W-1:0]          parked[$];
        sem_word_t                 due_words[$];
        int                        errors;

        function new();
            errors = 0;
            load_count('0);
        endfunction

        // register write: reload count, reopen, drop waiters silently
        function void load_count(input logic [CFG_W-1:0] value);
            count   = {1'b0, value};
            is_open = 1'b1;
            parked.delete();
        endfunction

        function int waiting();
            return due_words.size();
        endfunction

        function void push_word(input logic [1:0] st, input logic rv,
                                input logic [TID_W-1:0] tid, input logic lst);
            sem_word_t w;
            w.status     = st;
            w.rel_valid  = rv;
            w.rel_thread = tid;
            w.last       = lst;
            due_words.push_back(w);
        endfunction

        function void apply_request(input logic [1:0] fn, input logic [TID_W-1:0] tid);
            logic [TID_W-1:0] t;
            if (fn == FUNC_CLOSE) begin
                is_open = 1'b0;
                if (parked.size() == 0)
                    push_word(STATUS_OK, 1'b0, '0, 1'b1);
                while (parked.size() > 0) begin
                    t = parked.pop_front();
                    push_word(STATUS_OK, 1'b1, t, parked.size() == 0);
                end
            end else if (fn == FUNC_UNUSED) begin
                push_word(STATUS_OK, 1'b0, '0, 1'b1);
            end else if (!is_open) begin
                push_word(STATUS_CLOSED, 1'b0, '0, 1'b1);
            end else if (fn == FUNC_WAIT) begin
                if (count <= 0) begin
                    if (parked.size() >= WAIT_DEPTH) begin
                        push_word(STATUS_FULL, 1'b0, '0, 1'b1);
                    end else begin
                        parked.push_back(tid);
                        count = count - 1;
                        push_word(STATUS_BLOCKED, 1'b0, '0, 1'b1);
                    end
                end else begin
                    count = count - 1;
                    push_word(STATUS_OK, 1'b0, '0, 1'b1);
                end
            end else begin
                if (count < 0) begin
                    count = count + 1;
                    if (parked.size() > 0) begin
                        t = parked.pop_front();
                        push_word(STATUS_OK, 1'b1, t, 1'b1);
                    end else begin
                        push_word(STATUS_OK, 1'b0, '0, 1'b1);
                    end
                end else begin
                    // saturate at the top of the range
                    if (count < $signed(COUNT_MAX))
                        count = count + 1;
                    push_word(STATUS_OK, 1'b0, '0, 1'b1);
                end
            end
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(input sem_word_t got);
            sem_word_t want;
            if (due_words.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual status %0d rel %0d:%0d last %0d",
                         $time, got.status, got.rel_valid, got.rel_thread, got.last);
                errors++;
                return;
            end
            want = due_words.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("released_valid", want.rel_valid, got.rel_valid);
            compare_field("released_thread", want.rel_thread, got.rel_thread);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [TID_W-1:0] s_tdata;   // thread_id
    logic [1:0]       s_tuser;   // func
    logic             m_tvalid;
    logic             m_tready;
    logic [TID_W-1:0] m_tdata;   // released_thread
    logic [2:0]       m_tuser;   // status [1:0], released_valid [2]
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    sem_mirror sem;
    bit        no_idle;
    bit        long_stall_req;

    counting_semaphore_wait_queue_unit #(
        .QUEUE_DEPTH   (WAIT_DEPTH),
        .THREAD_ID_BITS(TID_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: random backpressure, plus one long hold on request
    initial
    begin
        bit stall_done;
        stall_done = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sem.match_result({m_tuser[1:0], m_tuser[2], m_tdata, m_tlast});
    end

    task automatic send_request(input logic [1:0] fn, input logic [TID_W-1:0] tid);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= tid;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sem.apply_request(fn, tid);
    endtask

    // drop valid and wait for every outstanding word
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sem.waiting() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_initial_count(input logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sem.load_count(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] start_count, input int wait_pct,
                             input bit hold_rx);
        int r;
        load_initial_count(start_count);
        // start the long receiver hold while requests keep coming
        if (hold_rx)
            long_stall_req = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                send_request(FUNC_CLOSE, TID_W'($urandom_range(0, 255)));
            else if (r < 4)
                send_request(FUNC_UNUSED, TID_W'($urandom_range(0, 255)));
            else if (r < 4 + wait_pct)
                send_request(FUNC_WAIT, TID_W'($urandom_range(0, 255)));
            else
                send_request(FUNC_SIGNAL, TID_W'($urandom_range(0, 255)));
        end
        // flush whatever is still parked
        send_request(FUNC_CLOSE, TID_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        #2_400_000;
        $display("counting_semaphore_wait_queue_unit verification failed");
        $finish;
    end

    initial
    begin
        sem            = new();
        no_idle        = 1'b0;
        long_stall_req = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_WAIT;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_initial_count('0);
        send_request(FUNC_WAIT, 8'h00);
        send_request(FUNC_WAIT, 8'hFF);
        send_request(FUNC_SIGNAL, 8'h01);
        send_request(FUNC_SIGNAL, 8'hFE);
        send_request(FUNC_SIGNAL, 8'h10);
        send_request(FUNC_WAIT, 8'h5A);
        send_request(FUNC_UNUSED, 8'hA5);
        // fill the wait queue, then overflow it
        for (int i = 0; i < WAIT_DEPTH; i++)
            send_request(FUNC_WAIT, TID_W'(i * 17));
        send_request(FUNC_WAIT, 8'h77);
        send_request(FUNC_CLOSE, 8'h00);
        send_request(FUNC_WAIT, 8'h33);
        send_request(FUNC_SIGNAL, 8'hCC);
        send_request(FUNC_UNUSED, 8'h0F);
        send_request(FUNC_CLOSE, 8'hF0);
        load_initial_count(16'hFFFF);
        send_request(FUNC_SIGNAL, 8'h80);
        send_request(FUNC_WAIT, 8'h7F);

        run_phase(16'hFFFF, 48, 1'b0);
        run_phase(16'h0000, 60, 1'b0);
        no_idle = 1'b1;
        run_phase(16'h0001, 50, 1'b0);
        no_idle = 1'b0;
        run_phase(16'h0003, 55, 1'b1);
        run_phase(CFG_W'($urandom_range(0, 65535)), 50, 1'b0);
        run_phase(16'h0002, 45, 1'b0);

        settle();
        repeat (10) @(negedge clk);
        if (sem.errors == 0 && sem.waiting() == 0)
            $display("counting_semaphore_wait_queue_unit verification clean");
        else
            $display("counting_semaphore_wait_queue_unit verification failed");
        $finish;
    end

endmodule
